[hw/rtl/sorted_list_table_engine_top_defines.svh]
// Assertion macros for the sorted list table engine.
// Included by the modules that carry concurrent checks; depends on nothing else.
`ifndef SORTED_LIST_TABLE_ENGINE_TOP_DEFINES_SVH
`define SORTED_LIST_TABLE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication under the synchronous reset.
`define SLTE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication under the synchronous reset.
`define SLTE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SLTE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SLTE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hw/rtl/slte_pkg.sv]
// Shared types, codes and widths of the sorted list table engine.
// Used by all modules of the block; depends on nothing.
package slte_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 7;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 7;

   localparam logic [KIND_W-1:0] REQ_INSERT   = 3'd0;
   localparam logic [KIND_W-1:0] REQ_CONTAINS = 3'd1;
   localparam logic [KIND_W-1:0] REQ_GET      = 3'd2;
   localparam logic [KIND_W-1:0] REQ_REMOVE   = 3'd3;
   localparam logic [KIND_W-1:0] REQ_REVERSE  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [VALUE_W-1:0] READ_MISS = {VALUE_W{1'b1}};

   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  read_value;
      logic                read_valid;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

[hw/rtl/slte_ram.sv]
// Entry storage of the sorted list table engine: one write port, two read ports.
// Read data is registered and only updated when a read is enabled; uses slte_pkg.
module slte_ram
   import slte_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   output logic [VALUE_W-1:0] rd_data_a,
   output logic [VALUE_W-1:0] rd_data_b,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data
);

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hw/rtl/slte_cmp.sv]
// Shared value comparator of the sorted list table engine.
// Signed greater-than for the insert walk, equality for the search; uses slte_pkg.
module slte_cmp
   import slte_pkg::*;
(
   input  logic [VALUE_W-1:0] key,
   input  logic [VALUE_W-1:0] entry,
   output logic               key_gt,
   output logic               key_eq
);

   assign key_gt = $signed(key) > $signed(entry);
   assign key_eq = key == entry;

endmodule

[hw/rtl/slte_ctrl.sv]
// Request sequencer of the sorted list table engine.
// Steps through the entry memory with the shared comparator; uses slte_pkg, slte_cmp.
`include "sorted_list_table_engine_top_defines.svh"

module slte_ctrl
   import slte_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]   req_position,
   input  logic               rsp_free,
   output logic               done,
   output result_type         result,
   output logic [CW-1:0]      count,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr_a,
   output logic [AW-1:0]      rd_addr_b,
   input  logic [VALUE_W-1:0] rd_data_a,
   input  logic [VALUE_W-1:0] rd_data_b,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [VALUE_W-1:0] wr_data
);

   localparam int MW = (CW > POS_W) ? CW : POS_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_EV  = 4'd2;
   localparam logic [3:0] S_CON_RD  = 4'd3;
   localparam logic [3:0] S_CON_EV  = 4'd4;
   localparam logic [3:0] S_GET_EV  = 4'd5;
   localparam logic [3:0] S_REM_RD  = 4'd6;
   localparam logic [3:0] S_REM_WR  = 4'd7;
   localparam logic [3:0] S_REV_RD  = 4'd8;
   localparam logic [3:0] S_REV_WLO = 4'd9;
   localparam logic [3:0] S_REV_WHI = 4'd10;
   localparam logic [3:0] S_FINISH  = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] carry_ff, carry_in;
   logic               shifting_ff, shifting_in;
   result_type         res_ff, res_in;

   logic               accept;
   logic               key_gt, key_eq;
   logic [CW-1:0]      idx_p1;
   logic [MW-1:0]      pos_ext, cnt_ext;
   logic               pos_in_range;
   logic               full;

   slte_cmp u_cmp (
      .key    (key_ff),
      .entry  (rd_data_a),
      .key_gt (key_gt),
      .key_eq (key_eq)
   );

   assign accept       = req_valid && req_ready;
   assign idx_p1       = idx_ff + 1'b1;
   assign pos_ext      = MW'(req_position);
   assign cnt_ext      = MW'(count_ff);
   assign pos_in_range = pos_ext < cnt_ext;
   assign full         = count_ff == CW'(DEPTH);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      hi_in       = hi_ff;
      key_in      = key_ff;
      carry_in    = carry_ff;
      shifting_in = shifting_ff;
      res_in      = res_ff;
      rd_en       = 1'b0;
      rd_addr_a   = idx_ff[AW-1:0];
      rd_addr_b   = hi_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = carry_ff;
      done        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in      = req_value;
               carry_in    = req_value;
               shifting_in = 1'b0;
               idx_in      = '0;
               res_in      = '0;
               state_in    = S_FINISH;
               case (req_kind)
                  REQ_INSERT: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  REQ_CONTAINS: begin
                     state_in = S_CON_RD;
                  end
                  REQ_GET: begin
                     if (pos_in_range) begin
                        rd_en     = 1'b1;
                        rd_addr_a = pos_ext[AW-1:0];
                        state_in  = S_GET_EV;
                     end else begin
                        res_in.read_value = READ_MISS;
                     end
                  end
                  REQ_REMOVE: begin
                     if (pos_in_range) begin
                        idx_in   = pos_ext[CW-1:0];
                        state_in = S_REM_RD;
                     end else begin
                        res_in.status = ST_RANGE;
                     end
                  end
                  REQ_REVERSE: begin
                     hi_in = count_ff - 1'b1;
                     if (count_ff > CW'(1)) begin
                        state_in = S_REV_RD;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            // Past the last entry the pending value lands at the tail.
            if (idx_ff == count_ff) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = S_INS_EV;
            end
         end
         S_INS_EV: begin
            // Once the slot is found, each entry is replaced by the one before it.
            if (shifting_ff || !key_gt) begin
               wr_en       = 1'b1;
               carry_in    = rd_data_a;
               shifting_in = 1'b1;
            end
            idx_in   = idx_p1;
            state_in = S_INS_RD;
         end
         S_CON_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CON_EV;
            end
         end
         S_CON_EV: begin
            if (key_eq) begin
               res_in.found = 1'b1;
               state_in     = S_FINISH;
            end else begin
               idx_in   = idx_p1;
               state_in = S_CON_RD;
            end
         end
         S_GET_EV: begin
            res_in.read_value = rd_data_a;
            res_in.read_valid = 1'b1;
            state_in          = S_FINISH;
         end
         S_REM_RD: begin
            if (idx_p1 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = idx_p1[AW-1:0];
               state_in  = S_REM_WR;
            end
         end
         S_REM_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_a;
            idx_in   = idx_p1;
            state_in = S_REM_RD;
         end
         S_REV_RD: begin
            if (idx_ff >= hi_ff) begin
               state_in = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = S_REV_WLO;
            end
         end
         S_REV_WLO: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_b;
            state_in = S_REV_WHI;
         end
         S_REV_WHI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff[AW-1:0];
            wr_data  = rd_data_a;
            idx_in   = idx_p1;
            hi_in    = hi_ff - 1'b1;
            state_in = S_REV_RD;
         end
         S_FINISH: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff      <= idx_in;
      hi_ff       <= hi_in;
      key_ff      <= key_in;
      carry_ff    <= carry_in;
      shifting_ff <= shifting_in;
      res_ff      <= res_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign result    = res_ff;
   assign count     = count_ff;

   `SLTE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH),
      "entry count above table depth")
   `SLTE_ASSERT_IMP(a_write_addr, clock, reset, wr_en, {1'b0, wr_addr} < (AW+1)'(DEPTH),
      "memory write outside table")
   `SLTE_ASSERT_NXT(a_read_use, clock, reset, rd_en,
      state_ff == S_INS_EV || state_ff == S_CON_EV || state_ff == S_GET_EV ||
      state_ff == S_REM_WR || state_ff == S_REV_WLO,
      "read data not consumed in the following cycle")
   `SLTE_ASSERT_NXT(a_full_drop, clock, reset, accept && req_kind == REQ_INSERT && full,
      state_ff == S_FINISH && res_ff.status == ST_FULL && count_ff == CW'(DEPTH),
      "insert into full table not dropped")

endmodule

[hw/rtl/sorted_list_table_engine_top.sv]
// Sorted list table engine: an ordered table of signed 32-bit values.
// Requests arrive on the req_ stream: tuser carries the kind (insert, contains,
// get, remove, reverse), tdata the value and position. Each request yields one
// response on the rsp_ stream with the found flag, read value, status and the
// entry count; tuser carries the read-valid flag.
// One request is handled at a time; req_tready is high only while the
// sequencer is idle. All table work goes through one entry memory with
// registered reads, so each request is a series of memory accesses:
//   insert    walks to the slot, then shifts the tail
//   contains  walks the entries, stopping at the first match
//   get       reads one entry, remove shifts the entries above the position down
//   reverse   swaps pairs from both ends (read pair, write low, write high)
// A finished response sits in an output register; when the receiver stalls,
// the sequencer holds its result until that register frees up.
// Reset clears the count and the handshake state; the memory needs no clearing
// pass since only entries below the count are ever read.
// Depends on slte_pkg, slte_ctrl, slte_ram.
module sorted_list_table_engine_top
   import slte_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // value[31:0], position[38:32], zero pad
   input  logic [2:0]  req_tuser,  // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // found[0], read_value[32:1], status[34:33],
                                   // entry_count[41:35], zero pad
   output logic        rsp_tuser   // read_valid
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

   logic               rsp_valid_ff;
   result_type         rsp_res_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_free;
   logic               done;
   result_type         result;
   logic [CW-1:0]      count;
   logic [MW-1:0]      count_ext;

   logic               rd_en;
   logic [AW-1:0]      rd_addr_a, rd_addr_b;
   logic [VALUE_W-1:0] rd_data_a, rd_data_b;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   slte_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_value    (req_tdata[VALUE_W-1:0]),
      .req_position (req_tdata[VALUE_W+POS_W-1:VALUE_W]),
      .rsp_free     (rsp_free),
      .done         (done),
      .result       (result),
      .count        (count),
      .rd_en        (rd_en),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .rd_data_a    (rd_data_a),
      .rd_data_b    (rd_data_b),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   slte_ram #(.DEPTH(DEPTH)) u_ram (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign count_ext = MW'(count);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_res_ff   <= result;
         rsp_count_ff <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_res_ff.status,
                        rsp_res_ff.read_value, rsp_res_ff.found};
   assign rsp_tuser  = rsp_res_ff.read_valid;

endmodule
